### hdl/koe_pkg.sv
// Package for the Euler-Cromer orbit step block.
// Holds default sizes, register indexes, the sequencer state type and the
// command type of the serial arithmetic unit. Depends on nothing.
package koe_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 28;
    localparam int STEP_BITS     = 32;
    localparam int INDEX_BITS    = 3;

    localparam logic [INDEX_BITS-1:0] REG_TIME_STEP   = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_START_POS_X = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_START_POS_Y = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_START_VEL_X = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_START_VEL_Y = 3'd4;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT,
        ST_R2,
        ST_R3,
        ST_PULL_Y_MUL,
        ST_PULL_Y_DIV,
        ST_PULL_X_MUL,
        ST_PULL_X_DIV,
        ST_DRIFT_Y,
        ST_DRIFT_X,
        ST_DONE
    } state_t;

endpackage

### hdl/koe_if.sv
// Handshake channels of the orbit step block: input item and result item.
// Depends on nothing; widths come in as parameters.
interface koe_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface koe_out_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] new_position_x;
    logic [W-1:0] new_position_y;
    logic [W-1:0] new_velocity_x;
    logic [W-1:0] new_velocity_y;
    logic [31:0]  step_index;
    logic         saturated;
    modport source (output valid, output new_position_x, output new_position_y,
                    output new_velocity_x, output new_velocity_y, output step_index,
                    output saturated, input ready);
    modport sink (input valid, input new_position_x, input new_position_y,
                  input new_velocity_x, input new_velocity_y, input step_index,
                  input saturated, output ready);
endinterface

### hdl/koe_serial_alu.sv
// Bit-serial arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit of result per cycle.
// Depends on koe_pkg for the command type.
module koe_serial_alu #(
    parameter int W = koe_pkg::WORD_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  koe_pkg::alu_cmd_t  cmd,
    input  logic [2*W-1:0]     a,
    input  logic [W-1:0]       b,
    output logic               done,
    output logic [2*W-1:0]     result
);
    localparam int CW = $clog2(2*W+1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    koe_pkg::alu_op_t   op_reg, op_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [2*W-1:0]     acc_reg, acc_next;
    logic [2*W-1:0]     num_reg, num_next;
    logic [W-1:0]       den_reg, den_next;
    logic [W+1:0]       rem_reg, rem_next;

    logic [W:0]         mul_sum;
    logic [W:0]         div_sh;
    logic [W+3:0]       sq_sh;
    logic [W+3:0]       sq_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        mul_sum   = {1'b0, acc_reg[2*W-1:W]} + {1'b0, (num_reg[0] ? den_reg : {W{1'b0}})};
        div_sh    = {rem_reg[W-1:0], num_reg[2*W-1]};
        sq_sh     = {rem_reg, num_reg[2*W-1:2*W-2]};
        sq_trial  = {2'b00, acc_reg[W-1:0], 2'b01};
        if (!busy_reg)
        begin
            if (cmd.start)
            begin
                busy_next = 1'b1;
                op_next   = cmd.op;
                acc_next  = '0;
                rem_next  = '0;
                case (cmd.op)
                    koe_pkg::ALU_MUL:
                    begin
                        num_next = {{W{1'b0}}, b};
                        den_next = a[W-1:0];
                        cnt_next = CW'(W);
                    end
                    koe_pkg::ALU_DIV:
                    begin
                        num_next = a;
                        den_next = b;
                        cnt_next = CW'(2*W);
                    end
                    default:
                    begin
                        num_next = a;
                        den_next = b;
                        cnt_next = CW'(W);
                    end
                endcase
            end
        end
        else
        begin
            case (op_reg)
                koe_pkg::ALU_MUL:
                begin
                    acc_next = {mul_sum, acc_reg[W-1:1]};
                    num_next = num_reg >> 1;
                end
                koe_pkg::ALU_DIV:
                begin
                    num_next = num_reg << 1;
                    if (div_sh >= {1'b0, den_reg})
                    begin
                        rem_next = {1'b0, div_sh - {1'b0, den_reg}};
                        acc_next = {acc_reg[2*W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {1'b0, div_sh};
                        acc_next = {acc_reg[2*W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    num_next = num_reg << 2;
                    if (sq_sh >= sq_trial)
                    begin
                        rem_next = (W+2)'(sq_sh - sq_trial);
                        acc_next = {acc_reg[2*W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = (W+2)'(sq_sh);
                        acc_next = {acc_reg[2*W-2:0], 1'b0};
                    end
                end
            endcase
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### hdl/kepler_orbit_euler_cromer_step.sv
// Top level of the Euler-Cromer two-body orbit step block.
// Depends on koe_pkg, koe_if.sv and koe_serial_alu.
//
// Usage: each input item on item_in advances the stored orbit by one step and
// yields exactly one result item on result_out. An item with restart set first
// reloads position and velocity from the start registers and clears the step
// count. Configuration writes use cfg_we / cfg_index / cfg_data, one per clock;
// the user makes them only while no item is in flight; the block does not check.
//
// Datapath: all arithmetic runs on one bit-serial unit that produces one result
// bit per cycle. A step uses eight multiplies, one square root and two divides;
// with a zero radius the cube and pull phases are skipped. One item is worked
// on at a time.
//
// The result sits in an output register, so item_in is ready again as soon
// as the result is loaded, even while result_out is stalled; a stalled
// receiver only holds the next result in its final state. Reset clears the
// step count, loads the default registers and orbit, and drops all valids.
module kepler_orbit_euler_cromer_step #(
    parameter int W = koe_pkg::WORD_BITS,
    parameter int F = koe_pkg::FRACTION_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [koe_pkg::INDEX_BITS-1:0]    cfg_index,
    input  logic [W-1:0]                      cfg_data,
    koe_in_if.sink                            item_in,
    koe_out_if.source                         result_out
);
    localparam int SB = koe_pkg::STEP_BITS;
    // Reset step: 0.0009 in the fixed point format, rounded.
    localparam logic [63:0] DT_RESET64 = ((64'd9 << F) + 64'd5000) / 64'd10000;
    localparam logic [W-2:0] DT_RESET  = DT_RESET64[W-2:0];
    localparam logic [W-1:0] ONE_FX    = W'(64'd1 << F);
    localparam logic [W-1:0] MAXPOS    = {1'b0, {(W-1){1'b1}}};

    koe_pkg::state_t    state_reg, state_next;

    logic [W-2:0]       dt_reg, dt_next;
    logic [W-1:0]       spx_reg, spx_next, spy_reg, spy_next;
    logic [W-1:0]       svx_reg, svx_next, svy_reg, svy_next;
    logic [W-1:0]       px_reg, px_next, py_reg, py_next;
    logic [W-1:0]       vx_reg, vx_next, vy_reg, vy_next;
    logic [SB-1:0]      steps_reg, steps_next;
    logic               flag_reg, flag_next;
    logic               launched_reg, launched_next;
    logic [2*W-1:0]     s_reg, s_next;
    logic [W-1:0]       r_reg, r_next;
    logic [W-1:0]       r3_reg, r3_next;

    logic               ov_reg, ov_next;
    logic [W-1:0]       opx_reg, opx_next, opy_reg, opy_next;
    logic [W-1:0]       ovx_reg, ovx_next, ovy_reg, ovy_next;
    logic [SB-1:0]      ostep_reg, ostep_next;
    logic               osat_reg, osat_next;

    koe_pkg::alu_cmd_t  alu_cmd;
    logic [2*W-1:0]     alu_a;
    logic [W-1:0]       alu_b;
    logic               alu_done;
    logic [2*W-1:0]     alu_result;

    logic               in_fire;
    logic               computing;
    logic               capture;
    logic               out_free;
    logic [W-1:0]       cube_val;
    logic               cube_clip;
    logic [W-1:0]       pull_mag;
    logic               pull_clip;
    logic [W-1:0]       drift_mag;
    logic               drift_clip;
    logic [W:0]         sum_res;
    logic [W-1:0]       term;

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] raw);
        return raw[W-1] ? (W'(0) - raw) : raw;
    endfunction

    // Returns {overflow, sum}; an overflow clips toward the sign of the operands.
    function automatic logic [W:0] sat_add(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W-1:0] s;
        s = x + y;
        if ((x[W-1] == y[W-1]) && (s[W-1] != x[W-1]))
        begin
            return {1'b1, (x[W-1] ? {1'b1, {(W-1){1'b0}}} : MAXPOS)};
        end
        return {1'b0, s};
    endfunction

    koe_serial_alu #(.W(W)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .a      (alu_a),
        .b      (alu_b),
        .done   (alu_done),
        .result (alu_result)
    );

    assign in_fire   = item_in.valid && item_in.ready;
    assign out_free  = !ov_reg || result_out.ready;
    assign computing = (state_reg != koe_pkg::ST_IDLE) && (state_reg != koe_pkg::ST_DONE);
    assign capture   = computing && launched_reg && alu_done;

    assign item_in.ready = (state_reg == koe_pkg::ST_IDLE);

    assign result_out.valid          = ov_reg;
    assign result_out.new_position_x = opx_reg;
    assign result_out.new_position_y = opy_reg;
    assign result_out.new_velocity_x = ovx_reg;
    assign result_out.new_velocity_y = ovy_reg;
    assign result_out.step_index     = ostep_reg;
    assign result_out.saturated      = osat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= koe_pkg::ST_IDLE;
            dt_reg       <= DT_RESET;
            spx_reg      <= ONE_FX;
            spy_reg      <= '0;
            svx_reg      <= '0;
            svy_reg      <= ONE_FX;
            px_reg       <= ONE_FX;
            py_reg       <= '0;
            vx_reg       <= '0;
            vy_reg       <= ONE_FX;
            steps_reg    <= '0;
            launched_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dt_reg       <= dt_next;
            spx_reg      <= spx_next;
            spy_reg      <= spy_next;
            svx_reg      <= svx_next;
            svy_reg      <= svy_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
            vx_reg       <= vx_next;
            vy_reg       <= vy_next;
            steps_reg    <= steps_next;
            launched_reg <= launched_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg  <= flag_next;
        s_reg     <= s_next;
        r_reg     <= r_next;
        r3_reg    <= r3_next;
        opx_reg   <= opx_next;
        opy_reg   <= opy_next;
        ovx_reg   <= ovx_next;
        ovy_reg   <= ovy_next;
        ostep_reg <= ostep_next;
        osat_reg  <= osat_next;
    end

    // Sequencer: each compute state launches the serial unit once and moves
    // on when its result comes back.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            koe_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = koe_pkg::ST_SQ_X;
                end
            end
            koe_pkg::ST_SQ_X:       if (capture) state_next = koe_pkg::ST_SQ_Y;
            koe_pkg::ST_SQ_Y:       if (capture) state_next = koe_pkg::ST_ROOT;
            koe_pkg::ST_ROOT:
            begin
                if (capture)
                begin
                    state_next = (alu_result[W-1:0] == '0) ? koe_pkg::ST_DRIFT_Y
                                                           : koe_pkg::ST_R2;
                end
            end
            koe_pkg::ST_R2:         if (capture) state_next = koe_pkg::ST_R3;
            koe_pkg::ST_R3:         if (capture) state_next = koe_pkg::ST_PULL_Y_MUL;
            koe_pkg::ST_PULL_Y_MUL: if (capture) state_next = koe_pkg::ST_PULL_Y_DIV;
            koe_pkg::ST_PULL_Y_DIV: if (capture) state_next = koe_pkg::ST_PULL_X_MUL;
            koe_pkg::ST_PULL_X_MUL: if (capture) state_next = koe_pkg::ST_PULL_X_DIV;
            koe_pkg::ST_PULL_X_DIV: if (capture) state_next = koe_pkg::ST_DRIFT_Y;
            koe_pkg::ST_DRIFT_Y:    if (capture) state_next = koe_pkg::ST_DRIFT_X;
            koe_pkg::ST_DRIFT_X:    if (capture) state_next = koe_pkg::ST_DONE;
            koe_pkg::ST_DONE:       if (out_free) state_next = koe_pkg::ST_IDLE;
            default:                state_next = koe_pkg::ST_IDLE;
        endcase
    end

    // Operand selection for the serial unit.
    always_comb
    begin
        alu_cmd.start = computing && !launched_reg;
        alu_cmd.op    = koe_pkg::ALU_MUL;
        alu_a         = '0;
        alu_b         = '0;
        case (state_reg)
            koe_pkg::ST_SQ_X:
            begin
                alu_a = {{W{1'b0}}, magnitude(px_reg)};
                alu_b = magnitude(px_reg);
            end
            koe_pkg::ST_SQ_Y:
            begin
                alu_a = {{W{1'b0}}, magnitude(py_reg)};
                alu_b = magnitude(py_reg);
            end
            koe_pkg::ST_ROOT:
            begin
                alu_cmd.op = koe_pkg::ALU_SQRT;
                alu_a      = s_reg;
            end
            koe_pkg::ST_R2:
            begin
                alu_a = {{W{1'b0}}, r_reg};
                alu_b = r_reg;
            end
            koe_pkg::ST_R3:
            begin
                alu_a = {{W{1'b0}}, r3_reg};
                alu_b = r_reg;
            end
            koe_pkg::ST_PULL_Y_MUL:
            begin
                alu_a = {{W{1'b0}}, magnitude(py_reg)};
                alu_b = {1'b0, dt_reg};
            end
            koe_pkg::ST_PULL_X_MUL:
            begin
                alu_a = {{W{1'b0}}, magnitude(px_reg)};
                alu_b = {1'b0, dt_reg};
            end
            koe_pkg::ST_PULL_Y_DIV, koe_pkg::ST_PULL_X_DIV:
            begin
                alu_cmd.op = koe_pkg::ALU_DIV;
                alu_a      = s_reg;
                alu_b      = r3_reg;
            end
            koe_pkg::ST_DRIFT_Y:
            begin
                alu_a = {{W{1'b0}}, magnitude(vy_reg)};
                alu_b = {1'b0, dt_reg};
            end
            koe_pkg::ST_DRIFT_X:
            begin
                alu_a = {{W{1'b0}}, magnitude(vx_reg)};
                alu_b = {1'b0, dt_reg};
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // Clipping of the serial results, shared by the x and y phases.
    always_comb
    begin
        cube_clip = (alu_result[2*W-1:W+F] != '0);
        cube_val  = cube_clip ? {W{1'b1}} : alu_result[W+F-1:F];
        pull_clip = (alu_result[2*W-1:W-1] != '0);
        pull_mag  = pull_clip ? MAXPOS : {1'b0, alu_result[W-2:0]};
        drift_clip = (alu_result[2*W-1:W-1+F] != '0);
        drift_mag  = drift_clip ? MAXPOS : {1'b0, alu_result[W-2+F:F]};
    end

    // Datapath and register updates.
    always_comb
    begin
        dt_next       = dt_reg;
        spx_next      = spx_reg;
        spy_next      = spy_reg;
        svx_next      = svx_reg;
        svy_next      = svy_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        steps_next    = steps_reg;
        flag_next     = flag_reg;
        s_next        = s_reg;
        r_next        = r_reg;
        r3_next       = r3_reg;
        ov_next       = ov_reg;
        opx_next      = opx_reg;
        opy_next      = opy_reg;
        ovx_next      = ovx_reg;
        ovy_next      = ovy_reg;
        ostep_next    = ostep_reg;
        osat_next     = osat_reg;
        sum_res       = '0;
        term          = '0;
        launched_next = launched_reg;

        if (alu_cmd.start)
        begin
            launched_next = 1'b1;
        end
        if (capture)
        begin
            launched_next = 1'b0;
        end

        if (ov_reg && result_out.ready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                koe_pkg::REG_TIME_STEP:   dt_next  = cfg_data[W-2:0];
                koe_pkg::REG_START_POS_X: spx_next = cfg_data;
                koe_pkg::REG_START_POS_Y: spy_next = cfg_data;
                koe_pkg::REG_START_VEL_X: svx_next = cfg_data;
                koe_pkg::REG_START_VEL_Y: svy_next = cfg_data;
                default:                  dt_next  = dt_reg;
            endcase
        end

        case (state_reg)
            koe_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    flag_next = 1'b0;
                    if (item_in.restart)
                    begin
                        px_next    = spx_reg;
                        py_next    = spy_reg;
                        vx_next    = svx_reg;
                        vy_next    = svy_reg;
                        steps_next = '0;
                    end
                end
            end
            koe_pkg::ST_SQ_X:
            begin
                if (capture) s_next = alu_result;
            end
            koe_pkg::ST_SQ_Y:
            begin
                if (capture) s_next = s_reg + alu_result;
            end
            koe_pkg::ST_ROOT:
            begin
                if (capture) r_next = alu_result[W-1:0];
            end
            koe_pkg::ST_R2:
            begin
                if (capture)
                begin
                    r3_next   = cube_val;
                    flag_next = flag_reg | cube_clip;
                end
            end
            koe_pkg::ST_R3:
            begin
                if (capture)
                begin
                    // A nonzero radius whose cube truncates to zero divides by one LSB.
                    if (cube_val == '0)
                    begin
                        r3_next   = W'(1);
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        r3_next   = cube_val;
                        flag_next = flag_reg | cube_clip;
                    end
                end
            end
            koe_pkg::ST_PULL_Y_MUL, koe_pkg::ST_PULL_X_MUL:
            begin
                if (capture) s_next = alu_result;
            end
            koe_pkg::ST_PULL_Y_DIV:
            begin
                if (capture)
                begin
                    term      = py_reg[W-1] ? pull_mag : (W'(0) - pull_mag);
                    sum_res   = sat_add(vy_reg, term);
                    vy_next   = sum_res[W-1:0];
                    flag_next = flag_reg | pull_clip | sum_res[W];
                end
            end
            koe_pkg::ST_PULL_X_DIV:
            begin
                if (capture)
                begin
                    term      = px_reg[W-1] ? pull_mag : (W'(0) - pull_mag);
                    sum_res   = sat_add(vx_reg, term);
                    vx_next   = sum_res[W-1:0];
                    flag_next = flag_reg | pull_clip | sum_res[W];
                end
            end
            koe_pkg::ST_DRIFT_Y:
            begin
                if (capture)
                begin
                    term      = vy_reg[W-1] ? (W'(0) - drift_mag) : drift_mag;
                    sum_res   = sat_add(py_reg, term);
                    py_next   = sum_res[W-1:0];
                    flag_next = flag_reg | drift_clip | sum_res[W];
                end
            end
            koe_pkg::ST_DRIFT_X:
            begin
                if (capture)
                begin
                    term      = vx_reg[W-1] ? (W'(0) - drift_mag) : drift_mag;
                    sum_res   = sat_add(px_reg, term);
                    px_next   = sum_res[W-1:0];
                    flag_next = flag_reg | drift_clip | sum_res[W];
                end
            end
            koe_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    steps_next = steps_reg + SB'(1);
                    ov_next    = 1'b1;
                    opx_next   = px_reg;
                    opy_next   = py_reg;
                    ovx_next   = vx_reg;
                    ovy_next   = vy_reg;
                    ostep_next = steps_reg + SB'(1);
                    osat_next  = flag_reg;
                end
            end
            default:
            begin
                flag_next = flag_reg;
            end
        endcase
    end

endmodule
